FILE: hdl/sla_pkg.sv
`default_nettype none
package sla_pkg;

   localparam logic [7:0] CH_CR  = 8'h0D;
   localparam logic [7:0] CH_LF  = 8'h0A;
   localparam logic [7:0] CH_BS  = 8'h08;
   localparam logic [7:0] CH_DEL = 8'h7F;

   localparam logic KIND_LINE  = 1'b0;
   localparam logic KIND_ERROR = 1'b1;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_REPLAY,
      ST_ERROR
   } state_type;

   // request from the controller to load the output register
   typedef struct packed {
      logic load;
      logic kind;
      logic last;
   } emit_type;

endpackage
`default_nettype wire

FILE: hdl/sla_channels.sv
`default_nettype none
interface sla_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] rx_byte;

   modport source (output valid, output rx_byte, input ready);
   modport sink (input valid, input rx_byte, output ready);
endinterface

interface sla_rsp_if;
   logic       valid;
   logic       ready;
   logic       kind;
   logic [7:0] line_byte;
   logic       last;

   modport source (output valid, output kind, output line_byte, output last, input ready);
   modport sink (input valid, input kind, input line_byte, input last, output ready);
endinterface
`default_nettype wire

FILE: hdl/serial_line_assembler.sv
// Serial line assembler: builds command lines from received bytes.
// req_if carries one received byte per item (rx_byte). rsp_if carries the
// results: line bytes (kind 0) with last on the final byte of a line, or a
// single line-too-long error (kind 1, line_byte 0, last 1).
// Ordinary bytes, backspace/delete and bytes dropped in discard mode are
// taken at one item per cycle while idle and give no result. Carriage
// return or line feed on a non-empty line starts a replay: the first
// byte is read into the store's read register and then loaded into the
// output register; the rest follow at one byte per cycle while rsp_if is
// ready, set by the single read port of the line store. A replay holds
// req_if.ready low until its last byte is loaded. An overflowing byte
// holds req_if.ready low while the error is loaded.
// When rsp_if stalls, the output register holds its item; replay and error
// delivery wait, and req_if.ready stays low until they are done. A result
// waiting in the output register does not block ordinary bytes.
// Reset clears the fill count, discard mode and the output valid; the
// store contents are not cleared, since only written entries are replayed.
`default_nettype none
module serial_line_assembler #(
   parameter int LINE_MAX = 64
) (
   input  wire logic  clock,
   input  wire logic  reset,
   sla_req_if.sink    req_if,
   sla_rsp_if.source  rsp_if
);

   localparam int AW = (LINE_MAX > 1) ? $clog2(LINE_MAX) : 1;
   localparam int CW = $clog2(LINE_MAX + 1);

   sla_pkg::emit_type emit;
   logic              out_free;
   logic              wr_en;
   logic [AW-1:0]     wr_addr;
   logic              rd_en;
   logic [AW-1:0]     rd_addr;
   logic [7:0]        rd_data;

   // output register
   logic              rsp_valid_ff;
   logic              rsp_kind_ff;
   logic [7:0]        rsp_byte_ff;
   logic              rsp_last_ff;

   assign out_free = !rsp_valid_ff || rsp_if.ready;

   sla_ctrl #(
      .LINE_MAX (LINE_MAX),
      .AW       (AW),
      .CW       (CW)
   ) u_ctrl (
      .clock    (clock),
      .reset    (reset),
      .in_valid (req_if.valid),
      .in_byte  (req_if.rx_byte),
      .in_ready (req_if.ready),
      .out_free (out_free),
      .emit     (emit),
      .wr_en    (wr_en),
      .wr_addr  (wr_addr),
      .rd_en    (rd_en),
      .rd_addr  (rd_addr)
   );

   sla_store #(
      .DEPTH (LINE_MAX),
      .AW    (AW)
   ) u_store (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (req_if.rx_byte),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   // advance valid: set on load, drop once the sink takes the item
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (emit.load) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_if.ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   // payload: error items carry a zero byte
   always_ff @(posedge clock) begin
      if (emit.load) begin
         rsp_kind_ff <= emit.kind;
         rsp_last_ff <= emit.last;
         rsp_byte_ff <= (emit.kind == sla_pkg::KIND_ERROR) ? 8'h00 : rd_data;
      end
   end

   assign rsp_if.valid     = rsp_valid_ff;
   assign rsp_if.kind      = rsp_kind_ff;
   assign rsp_if.line_byte = rsp_byte_ff;
   assign rsp_if.last      = rsp_last_ff;

endmodule
`default_nettype wire

FILE: hdl/sla_store.sv
`default_nettype none
module sla_store #(
   parameter int DEPTH = 64,
   parameter int AW    = 6
) (
   input  wire logic          clock,
   input  wire logic          wr_en,
   input  wire logic [AW-1:0] wr_addr,
   input  wire logic [7:0]    wr_data,
   input  wire logic          rd_en,
   input  wire logic [AW-1:0] rd_addr,
   output logic [7:0]         rd_data
);

   logic [7:0] mem [DEPTH];
   logic [7:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // hold read data until the next read
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule
`default_nettype wire

FILE: hdl/sla_ctrl.sv
`default_nettype none
module sla_ctrl #(
   parameter int LINE_MAX = 64,
   parameter int AW       = 6,
   parameter int CW       = 7
) (
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          in_valid,
   input  wire logic [7:0]    in_byte,
   output logic               in_ready,
   input  wire logic          out_free,
   output sla_pkg::emit_type  emit,
   output logic               wr_en,
   output logic [AW-1:0]      wr_addr,
   output logic               rd_en,
   output logic [AW-1:0]      rd_addr
);

   sla_pkg::state_type state_ff, state_in;
   logic [CW-1:0] fill_ff, fill_in;
   logic          disc_ff, disc_in;
   logic [AW-1:0] idx_ff, idx_in;

   logic          take;
   logic          is_eol;
   logic          is_bs;
   logic          has_room;
   logic          at_last;

   assign take     = in_valid && in_ready;
   assign is_eol   = (in_byte == sla_pkg::CH_CR) || (in_byte == sla_pkg::CH_LF);
   assign is_bs    = (in_byte == sla_pkg::CH_BS) || (in_byte == sla_pkg::CH_DEL);
   assign has_room = fill_ff < CW'(LINE_MAX);
   assign at_last  = CW'(idx_ff) == (fill_ff - CW'(1));

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         sla_pkg::ST_IDLE: begin
            if (take && is_eol && !disc_ff && (fill_ff != '0)) begin
               state_in = sla_pkg::ST_REPLAY;
            end else if (take && !is_eol && !disc_ff && !is_bs && !has_room) begin
               state_in = sla_pkg::ST_ERROR;
            end
         end
         sla_pkg::ST_REPLAY: begin
            if (out_free && at_last) begin
               state_in = sla_pkg::ST_IDLE;
            end
         end
         sla_pkg::ST_ERROR: begin
            if (out_free) begin
               state_in = sla_pkg::ST_IDLE;
            end
         end
         default: state_in = sla_pkg::ST_IDLE;
      endcase
   end

   // outputs and counter updates
   always_comb begin
      in_ready  = 1'b0;
      emit      = '0;
      wr_en     = 1'b0;
      wr_addr   = fill_ff[AW-1:0];
      rd_en     = 1'b0;
      rd_addr   = '0;
      fill_in   = fill_ff;
      disc_in   = disc_ff;
      idx_in    = idx_ff;
      unique case (state_ff)
         sla_pkg::ST_IDLE: begin
            in_ready = 1'b1;
            if (take) begin
               if (is_eol) begin
                  if (disc_ff) begin
                     // end of discard: drop silently
                     disc_in = 1'b0;
                     fill_in = '0;
                  end else if (fill_ff != '0) begin
                     // start replay with the first entry
                     rd_en  = 1'b1;
                     idx_in = '0;
                  end
               end else if (disc_ff) begin
                  // drop everything until end of line
               end else if (is_bs) begin
                  if (fill_ff != '0) begin
                     fill_in = fill_ff - CW'(1);
                  end
               end else if (has_room) begin
                  wr_en   = 1'b1;
                  fill_in = fill_ff + CW'(1);
               end else begin
                  fill_in = '0;
                  disc_in = 1'b1;
               end
            end
         end
         sla_pkg::ST_REPLAY: begin
            if (out_free) begin
               emit.load = 1'b1;
               emit.kind = sla_pkg::KIND_LINE;
               emit.last = at_last;
               if (at_last) begin
                  fill_in = '0;
               end else begin
                  // fetch the next entry while this one leaves
                  rd_en   = 1'b1;
                  rd_addr = idx_ff + AW'(1);
                  idx_in  = idx_ff + AW'(1);
               end
            end
         end
         sla_pkg::ST_ERROR: begin
            if (out_free) begin
               emit.load = 1'b1;
               emit.kind = sla_pkg::KIND_ERROR;
               emit.last = 1'b1;
            end
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= sla_pkg::ST_IDLE;
         fill_ff  <= '0;
         disc_ff  <= 1'b0;
         idx_ff   <= '0;
      end else begin
         state_ff <= state_in;
         fill_ff  <= fill_in;
         disc_ff  <= disc_in;
         idx_ff   <= idx_in;
      end
   end

   a_fill_bound: assert property (@(posedge clock) disable iff (reset)
      fill_ff <= CW'(LINE_MAX))
      else $error("fill count beyond store depth");

   a_replay_idx: assert property (@(posedge clock) disable iff (reset)
      (state_ff == sla_pkg::ST_REPLAY) |-> (CW'(idx_ff) < fill_ff))
      else $error("replay index past fill count");

   a_disc_empty: assert property (@(posedge clock) disable iff (reset)
      disc_ff |-> (fill_ff == '0))
      else $error("store not empty while discarding");

   a_emit_free: assert property (@(posedge clock) disable iff (reset)
      emit.load |-> (out_free && (state_ff != sla_pkg::ST_IDLE)))
      else $error("result loaded into a busy output register");

endmodule
`default_nettype wire

FILE: test/tb.sv
`timescale 1ns / 100ps
`default_nettype none
module tb;

   localparam int LINE_MAX = 64;
   localparam int REPORT_LIMIT = 10;
   // Longest stretch without a handshake on either side before the run is
   // declared hung; random idles and stalls stay far below it.
   localparam int QUIET_LIMIT = 5000;
   localparam int PHASE_BYTES = 70;

   typedef struct packed {
      logic       kind;
      logic [7:0] line_byte;
      logic       last;
   } line_result_type;

   logic clock = 1'b0;
   logic reset;

   sla_req_if req_chan ();
   sla_rsp_if rsp_chan ();

   serial_line_assembler #(
      .LINE_MAX(LINE_MAX)
   ) i_dut (
      .clock  (clock),
      .reset  (reset),
      .req_if (req_chan),
      .rsp_if (rsp_chan)
   );

   always #10 clock = ~clock;

   // Stimulus bytes waiting for the driver, and results the line model says
   // must come out, oldest first.
   logic [7:0]      rx_stream[$];
   line_result_type line_results[$];

   // Private copy of the assembler state.
   logic [7:0] line_copy [LINE_MAX];
   logic [6:0] line_fill;
   logic       discard_mode;

   int sender_idle_pct;
   int receiver_stall_pct;
   int bytes_taken;
   int results_checked;
   int lines_replayed;
   int overflows_seen;
   int mismatch_count;
   int quiet_cycles;

   // Line model: feed one accepted byte, queue the results it causes.
   task automatic assemble_byte(input logic [7:0] rx);
      line_result_type res;
      if (rx == sla_pkg::CH_CR || rx == sla_pkg::CH_LF) begin
         if (discard_mode) begin
            // end of discard: leave silently with an empty line
            discard_mode = 1'b0;
            line_fill = '0;
         end else if (line_fill != 0) begin
            for (int i = 0; i < line_fill; i++) begin
               res.kind = sla_pkg::KIND_LINE;
               res.line_byte = line_copy[i];
               res.last = (i == line_fill - 1);
               line_results.push_back(res);
            end
            lines_replayed++;
            line_fill = '0;
         end
      end else if (discard_mode) begin
         // drop everything up to the next end of line
      end else if (rx == sla_pkg::CH_BS || rx == sla_pkg::CH_DEL) begin
         if (line_fill != 0)
            line_fill--;
      end else if (line_fill < LINE_MAX) begin
         line_copy[line_fill[5:0]] = rx;
         line_fill++;
      end else begin
         // store full: flush it, flag the error, then discard
         line_fill = '0;
         discard_mode = 1'b1;
         res.kind = sla_pkg::KIND_ERROR;
         res.line_byte = 8'h00;
         res.last = 1'b1;
         line_results.push_back(res);
         overflows_seen++;
      end
   endtask

   task automatic note_failure(input string what);
      mismatch_count++;
      if (mismatch_count <= REPORT_LIMIT)
         $display("%0t: %s", $realtime, what);
   endtask

   // Driver: hold an item until it is taken, then advance to the next one
   // or idle. The model is updated at the accepting edge.
   always @(posedge clock) begin
      if (reset) begin
         req_chan.valid <= 1'b0;
      end else begin
         if (req_chan.valid && req_chan.ready) begin
            assemble_byte(req_chan.rx_byte);
            bytes_taken++;
         end
         if (!req_chan.valid || req_chan.ready) begin
            if (rx_stream.size() > 0 && $urandom_range(99) >= sender_idle_pct) begin
               req_chan.valid <= 1'b1;
               req_chan.rx_byte <= rx_stream.pop_front();
            end else begin
               req_chan.valid <= 1'b0;
            end
         end
      end
   end

   // Monitor: check each taken result against the oldest expected one,
   // and pick a fresh ready for the next cycle.
   always @(posedge clock) begin
      line_result_type want;
      if (reset) begin
         rsp_chan.ready <= 1'b0;
      end else begin
         if (rsp_chan.valid && rsp_chan.ready) begin
            if (line_results.size() == 0) begin
               note_failure($sformatf("unexpected result kind=%0b byte=%02h last=%0b",
                  rsp_chan.kind, rsp_chan.line_byte, rsp_chan.last));
            end else begin
               want = line_results.pop_front();
               results_checked++;
               if (rsp_chan.kind !== want.kind || rsp_chan.line_byte !== want.line_byte ||
                     rsp_chan.last !== want.last)
                  note_failure($sformatf({"result mismatch: expected kind=%0b byte=%02h ",
                     "last=%0b, got kind=%0b byte=%02h last=%0b"},
                     want.kind, want.line_byte, want.last,
                     rsp_chan.kind, rsp_chan.line_byte, rsp_chan.last));
            end
         end
         rsp_chan.ready <= ($urandom_range(99) >= receiver_stall_pct);
      end
   end

   // Watchdog: count cycles with no handshake on either channel.
   always @(posedge clock) begin
      if (reset || (req_chan.valid && req_chan.ready) ||
            (rsp_chan.valid && rsp_chan.ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= QUIET_LIMIT) begin
         $display("Timeout: no item moved for %0d cycles", QUIET_LIMIT);
         $display("Some tests failed");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   // Any byte except the line ends; edit codes only when asked for.
   function automatic logic [7:0] random_byte(input bit allow_edit);
      logic [7:0] b;
      do
         b = 8'($urandom_range(255));
      while (b == sla_pkg::CH_CR || b == sla_pkg::CH_LF ||
             (!allow_edit && (b == sla_pkg::CH_BS || b == sla_pkg::CH_DEL)));
      return b;
   endfunction

   function automatic logic [7:0] random_line_end();
      return $urandom_range(1) ? sla_pkg::CH_CR : sla_pkg::CH_LF;
   endfunction

   // Fill the store to the brim, optionally with one edit near the top,
   // then either end the line or push one byte over and ride out discard.
   task automatic queue_long_line(input bit overflow);
      for (int i = 0; i < LINE_MAX; i++)
         rx_stream.push_back(random_byte(1'b0));
      if ($urandom_range(1)) begin
         rx_stream.push_back($urandom_range(1) ? sla_pkg::CH_BS : sla_pkg::CH_DEL);
         rx_stream.push_back(random_byte(1'b0));
      end
      if (overflow) begin
         rx_stream.push_back(random_byte(1'b0));
         repeat ($urandom_range(4))
            rx_stream.push_back(random_byte(1'b1));
      end
      rx_stream.push_back(random_line_end());
   endtask

   task automatic queue_random_phase(input bit overflow);
      int start_count;
      int long_at;
      bit long_done;
      start_count = bytes_taken + rx_stream.size();
      long_at = $urandom_range(PHASE_BYTES / 10);
      long_done = 1'b0;
      while (bytes_taken + rx_stream.size() - start_count < PHASE_BYTES) begin
         if (!long_done && bytes_taken + rx_stream.size() - start_count >= long_at) begin
            queue_long_line(overflow);
            long_done = 1'b1;
         end else if ($urandom_range(99) < 15) begin
            // noise: any byte at all, line ends included
            repeat ($urandom_range(3, 1))
               rx_stream.push_back(8'($urandom_range(255)));
         end else begin
            repeat ($urandom_range(10, 1))
               rx_stream.push_back(($urandom_range(99) < 12) ?
                  ($urandom_range(1) ? sla_pkg::CH_BS : sla_pkg::CH_DEL) :
                  random_byte(1'b0));
            rx_stream.push_back(random_line_end());
         end
      end
   endtask

   // Wait on the falling edge so the driver's updates of this cycle are seen.
   task automatic wait_drained();
      do
         @(negedge clock);
      while (rx_stream.size() > 0 || req_chan.valid || line_results.size() > 0);
   endtask

   initial begin
      int sender_pct [4];
      int receiver_pct [4];
      sender_pct = '{0, 53, 0, 25};
      receiver_pct = '{0, 0, 53, 25};

      reset = 1'b1;
      req_chan.valid = 1'b0;
      req_chan.rx_byte = 8'h00;
      rsp_chan.ready = 1'b0;
      line_fill = '0;
      discard_mode = 1'b0;
      sender_idle_pct = 0;
      receiver_stall_pct = 0;
      bytes_taken = 0;
      results_checked = 0;
      lines_replayed = 0;
      overflows_seen = 0;
      mismatch_count = 0;
      quiet_cycles = 0;

      repeat (11) @(posedge clock);
      reset <= 1'b0;

      // Directed opening: empty line ends, edits on an empty line, the byte
      // extremes with edits in between, a one-byte line, and neighbors of
      // the control codes erased back to an empty line.
      rx_stream = '{sla_pkg::CH_CR, sla_pkg::CH_LF, sla_pkg::CH_BS, sla_pkg::CH_DEL,
                    8'h00, 8'hFF, 8'h80, 8'h7E, sla_pkg::CH_BS, 8'h41, sla_pkg::CH_DEL,
                    8'h01, sla_pkg::CH_CR,
                    8'h55, sla_pkg::CH_LF,
                    8'hAA, 8'h0B, 8'h0C, 8'h09, sla_pkg::CH_BS, sla_pkg::CH_BS,
                    sla_pkg::CH_DEL, sla_pkg::CH_BS, sla_pkg::CH_CR};

      // One phase per idle setting; full lines and overflows alternate.
      for (int p = 0; p < 4; p++) begin
         sender_idle_pct = sender_pct[p];
         receiver_stall_pct = receiver_pct[p];
         queue_random_phase(p[0]);
         wait_drained();
      end

      // Let any stray result surface before closing.
      repeat (8) @(posedge clock);

      $display("Covered %0d bytes over four idle settings: %0d lines replayed,",
         bytes_taken, lines_replayed);
      $display("%0d overflows, %0d results checked, %0d mismatches.",
         overflows_seen, results_checked, mismatch_count);
      if (mismatch_count == 0 && line_results.size() == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

endmodule
`default_nettype wire
